// ----- design/tilt_median_differential_drive_defines.svh -----
// ----------------------------------------------------------------------------
// tilt_median_differential_drive_defines
// assertion macros shared by the checker of the tilt drive block
// ----------------------------------------------------------------------------
`ifndef TILT_MEDIAN_DIFFERENTIAL_DRIVE_DEFINES_SVH
`define TILT_MEDIAN_DIFFERENTIAL_DRIVE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TMDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TMDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tmdd_pkg.sv -----
// ----------------------------------------------------------------------------
// tmdd_pkg
// types, constants, microcode program and helper functions of the tilt drive
// ----------------------------------------------------------------------------
package tmdd_pkg;

  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    OP_SORT_EVEN,
    OP_SORT_ODD,
    OP_SCALE_P,
    OP_SCALE_R,
    OP_RECIP,
    OP_FIX_P,
    OP_FIX_R,
    OP_MIX
  } op_e;

  typedef enum logic {
    COND_NONE,
    COND_PASS
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic active;
    op_e  op;
  } seq_ctrl_t;

  typedef struct packed {
    logic       fwd;
    logic [7:0] duty;
  } drive_t;

  localparam logic [STEP_W-1:0] STEP_SORT = 4'd0;

  localparam logic signed [7:0] ANGLE_MAX   = 8'sd90;
  localparam logic        [7:0] ANGLE_BIAS  = 8'd90;
  localparam logic       [15:0] PITCH_SCALE = 16'd254;
  localparam logic       [15:0] ROLL_SCALE  = 16'd100;
  localparam logic       [15:0] DIV_BY      = 16'd180;
  // floor(2^23 / 180); truncated quotient is exact or one low
  localparam logic       [31:0] RECIP_M     = 32'd46603;
  localparam int                RECIP_SHIFT = 23;
  localparam logic        [8:0] PITCH_OFS   = 9'd127;
  localparam logic        [8:0] ROLL_OFS    = 9'd50;
  localparam logic signed [8:0] DEADBAND    = 9'sd20;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_MIX, cond: COND_NONE, target: STEP_SORT, last: 1'b1};
    unique case (step)
      4'd0:    w = '{op: OP_SORT_EVEN, cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd1:    w = '{op: OP_SORT_ODD,  cond: COND_PASS, target: STEP_SORT, last: 1'b0};
      4'd2:    w = '{op: OP_SCALE_P,   cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd3:    w = '{op: OP_RECIP,     cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd4:    w = '{op: OP_FIX_P,     cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd5:    w = '{op: OP_SCALE_R,   cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd6:    w = '{op: OP_RECIP,     cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd7:    w = '{op: OP_FIX_R,     cond: COND_NONE, target: STEP_SORT, last: 1'b0};
      4'd8:    w = '{op: OP_MIX,       cond: COND_NONE, target: STEP_SORT, last: 1'b1};
      default: w = '{op: OP_MIX,       cond: COND_NONE, target: STEP_SORT, last: 1'b1};
    endcase
    return w;
  endfunction

  function automatic logic signed [7:0] sat_angle(input logic signed [7:0] a);
    logic signed [7:0] r;
    r = a;
    if (a > ANGLE_MAX) begin
      r = ANGLE_MAX;
    end else if (a < -ANGLE_MAX) begin
      r = -ANGLE_MAX;
    end
    return r;
  endfunction

  function automatic drive_t drive_side(input logic signed [8:0] speed);
    drive_t            d;
    logic signed [8:0] s;
    logic        [8:0] mag;
    s = speed;
    if (speed < DEADBAND && speed > -DEADBAND) begin
      s = 9'sd0;
    end
    mag    = s[8] ? 9'(-s) : 9'(s);
    d.fwd  = ~s[8];
    d.duty = mag[7:0];
    return d;
  endfunction

endpackage

// ----- design/tmdd_seq.sv -----
// ----------------------------------------------------------------------------
// tmdd_seq
// microcode sequencer: step counter, sort pass counter and program rom
// ----------------------------------------------------------------------------
module tmdd_seq #(
  parameter int WINDOW = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                hold_i,
  output tmdd_pkg::seq_ctrl_t ctrl_o
);

  // enough odd/even pass pairs for a full transposition sort
  localparam int PASSES = (WINDOW + 1) / 2;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;

  logic                        busy_q, busy_d;
  logic [tmdd_pkg::STEP_W-1:0] step_q, step_d;
  logic [PASS_W-1:0]           pass_q, pass_d;
  tmdd_pkg::ucode_t            word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      pass_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      pass_q <= pass_d;
    end
  end

  always_comb begin
    word   = tmdd_pkg::ucode_rom(step_q);
    busy_d = busy_q;
    step_d = step_q;
    pass_d = pass_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = tmdd_pkg::STEP_SORT;
        pass_d = '0;
      end
    end else if (!hold_i) begin
      if (word.cond == tmdd_pkg::COND_PASS && pass_q != PASS_W'(PASSES - 1)) begin
        step_d = word.target;
        pass_d = pass_q + 1'b1;
      end else if (word.last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    ctrl_o.active = busy_q;
    ctrl_o.op     = word.op;
  end

endmodule

// ----- design/tilt_median_differential_drive.sv -----
// ----------------------------------------------------------------------------
// tilt_median_differential_drive
// median-of-window tilt filter feeding a differential drive mixer
// ----------------------------------------------------------------------------
// Each request carries one pitch/roll pair, saturated to +-90 degrees and
// stored in a window of WINDOW samples; a request that does not close the
// window is taken whenever no program runs. The request that closes it
// starts a microcoded program that sorts both windows in place with
// odd/even compare-swap passes, scales and divides the medians with one
// shared reciprocal multiplier, and mixes them into left and right drive.
// While that program runs no request is taken; the result then waits in
// an output register while the next window fills. A result that is not
// taken before the next program reaches its last step holds the sequencer
// on that step.
module tilt_median_differential_drive #(
  parameter int WINDOW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [7:0] pitch_angle_i,
  input  logic signed [7:0] roll_angle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              left_forward_o,
  output logic        [7:0] left_duty_o,
  output logic              right_forward_o,
  output logic        [7:0] right_duty_o
);

  localparam int CNT_W = $clog2(WINDOW);
  localparam int MID   = WINDOW / 2;

  logic signed [7:0] pitch_q [WINDOW];
  logic signed [7:0] pitch_d [WINDOW];
  logic signed [7:0] roll_q  [WINDOW];
  logic signed [7:0] roll_d  [WINDOW];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       acc_q, acc_d;
  logic [7:0]        quo_q, quo_d;
  logic [7:0]        mp_q, mp_d;
  logic [7:0]        mr_q, mr_d;
  logic              out_valid_q, out_valid_d;
  tmdd_pkg::drive_t  left_q, left_d;
  tmdd_pkg::drive_t  right_q, right_d;

  tmdd_pkg::seq_ctrl_t ctrl;
  logic                in_acc;
  logic                last_item;
  logic                hold;
  logic                exec;
  logic                odd_pass;
  logic [7:0]          biased;
  logic [31:0]         prod;
  logic [15:0]         rem;
  logic                corr;
  logic [8:0]          quo_fix;
  logic signed [7:0]   mp_s, mr_s, mr_eff;
  logic signed [8:0]   left_sp, right_sp;

  assign in_ready_o = ~ctrl.active;
  assign in_acc     = in_valid_i & in_ready_o;
  assign last_item  = (cnt_q == CNT_W'(WINDOW - 1));
  // result register still full when the mix step wants it
  assign hold = (ctrl.op == tmdd_pkg::OP_MIX) & out_valid_q & ~out_ready_i;
  assign exec = ctrl.active & ~hold;

  tmdd_seq #(
    .WINDOW (WINDOW)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc & last_item),
    .hold_i  (hold),
    .ctrl_o  (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_d;
    roll_q  <= roll_d;
    acc_q   <= acc_d;
    quo_q   <= quo_d;
    mp_q    <= mp_d;
    mr_q    <= mr_d;
    left_q  <= left_d;
    right_q <= right_d;
  end

  // sample windows: store on request, compare-swap during sort steps
  always_comb begin
    pitch_d  = pitch_q;
    roll_d   = roll_q;
    cnt_d    = cnt_q;
    odd_pass = (ctrl.op == tmdd_pkg::OP_SORT_ODD);
    if (in_acc) begin
      pitch_d[cnt_q] = tmdd_pkg::sat_angle(pitch_angle_i);
      roll_d[cnt_q]  = tmdd_pkg::sat_angle(roll_angle_i);
      cnt_d          = last_item ? '0 : cnt_q + 1'b1;
    end
    if (exec && (ctrl.op == tmdd_pkg::OP_SORT_EVEN || odd_pass)) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        if (i[0] == odd_pass) begin
          if (pitch_q[i] > pitch_q[i+1]) begin
            pitch_d[i]   = pitch_q[i+1];
            pitch_d[i+1] = pitch_q[i];
          end
          if (roll_q[i] > roll_q[i+1]) begin
            roll_d[i]   = roll_q[i+1];
            roll_d[i+1] = roll_q[i];
          end
        end
      end
    end
  end

  // arithmetic datapath
  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    mp_d   = mp_q;
    mr_d   = mr_q;
    biased = (ctrl.op == tmdd_pkg::OP_SCALE_P) ? $unsigned(pitch_q[MID]) : $unsigned(roll_q[MID]);
    biased = biased + tmdd_pkg::ANGLE_BIAS;
    prod   = 32'(acc_q) * tmdd_pkg::RECIP_M;
    rem    = acc_q - 16'(16'(quo_q) * tmdd_pkg::DIV_BY);
    corr   = (rem >= tmdd_pkg::DIV_BY);
    quo_fix = 9'(quo_q) + 9'(corr);
    if (exec) begin
      unique case (ctrl.op)
        tmdd_pkg::OP_SCALE_P: acc_d = 16'(16'(biased) * tmdd_pkg::PITCH_SCALE);
        tmdd_pkg::OP_SCALE_R: acc_d = 16'(16'(biased) * tmdd_pkg::ROLL_SCALE);
        tmdd_pkg::OP_RECIP:   quo_d = 8'(prod >> tmdd_pkg::RECIP_SHIFT);
        tmdd_pkg::OP_FIX_P:   mp_d  = 8'(quo_fix - tmdd_pkg::PITCH_OFS);
        tmdd_pkg::OP_FIX_R:   mr_d  = 8'(quo_fix - tmdd_pkg::ROLL_OFS);
        default: ;
      endcase
    end
  end

  // mixer and result register
  always_comb begin
    mp_s     = $signed(mp_q);
    mr_s     = $signed(mr_q);
    mr_eff   = (mp_s > 8'sd0) ? -mr_s : mr_s;
    left_sp  = 9'(mp_s) - 9'(mr_eff);
    right_sp = 9'(mp_s) + 9'(mr_eff);
    left_d   = left_q;
    right_d  = right_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (exec && ctrl.op == tmdd_pkg::OP_MIX) begin
      left_d      = tmdd_pkg::drive_side(left_sp);
      right_d     = tmdd_pkg::drive_side(right_sp);
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_forward_o  = left_q.fwd;
  assign left_duty_o     = left_q.duty;
  assign right_forward_o = right_q.fwd;
  assign right_duty_o    = right_q.duty;

endmodule

// ----- design/tmdd_checker.sv -----
// ----------------------------------------------------------------------------
// tmdd_checker
// port-level checks of the tilt drive block, bound to the top level
// ----------------------------------------------------------------------------
`include "tilt_median_differential_drive_defines.svh"

module tmdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       left_forward_o,
  input logic [7:0] left_duty_o,
  input logic       right_forward_o,
  input logic [7:0] right_duty_o
);

  // a pending result stays until taken
  `TMDD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped before taken")

  // duty within mixer range and outside the dead band
  `TMDD_ASSERT_NOW(a_duty_range, clk_i, rst_ni, out_valid_o, left_duty_o <= 8'd177 && right_duty_o <= 8'd177 && (left_duty_o == 8'd0 || left_duty_o >= 8'd20) && (right_duty_o == 8'd0 || right_duty_o >= 8'd20), "duty out of range or in dead band")

  // a stopped side reports forward
  `TMDD_ASSERT_NOW(a_left_zero_fwd, clk_i, rst_ni, out_valid_o && left_duty_o == 8'd0, left_forward_o, "left zero duty not forward")

  `TMDD_ASSERT_NOW(a_right_zero_fwd, clk_i, rst_ni, out_valid_o && right_duty_o == 8'd0, right_forward_o, "right zero duty not forward")

endmodule

bind tilt_median_differential_drive tmdd_checker u_tmdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .left_forward_o  (left_forward_o),
  .left_duty_o     (left_duty_o),
  .right_forward_o (right_forward_o),
  .right_duty_o    (right_duty_o)
);
